@@ sv/three_level_token_bucket_policer_macros.svh @@
// Assertion macros for the three-level token bucket policer.
// No dependencies.
`ifndef THREE_LEVEL_TOKEN_BUCKET_POLICER_MACROS_SVH
`define THREE_LEVEL_TOKEN_BUCKET_POLICER_MACROS_SVH
`define TLP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ sv/tlp_pkg.sv @@
// Shared types and constants for the token bucket policer.
// No dependencies.
package tlp_pkg;
  localparam logic [63:0] MAX_ELAPSED = 64'd1000000000;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [1:0] LVL_FLOW = 2'd0;
  localparam logic [1:0] LVL_PAIR = 2'd1;
  localparam logic [1:0] LVL_HOST = 2'd2;
  localparam logic [1:0] HIT_NONE = 2'd0;
  localparam logic [1:0] HIT_FLOW = 2'd1;
  localparam logic [1:0] HIT_PAIR = 2'd2;
  localparam logic [1:0] HIT_HOST = 2'd3;
  localparam logic [1:0] CLS_IP = 2'd1;
  localparam logic [1:0] CLS_L4 = 2'd2;

  typedef struct packed {
    logic        install;
    logic [1:0]  level;
    logic [5:0]  idx;
    logic [15:0] rate;
    logic [1:0]  hclass;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] ports;
    logic [39:0] bytes;
    logic [63:0] now;
  } req_t;
endpackage

@@ sv/three_level_token_bucket_policer.sv @@
// Top level of the three-level token bucket policer.
// Depends on tlp_pkg, tlp_front, tlp_back and the macros header.
//
// Use: drive the request fields with start high; a beat is taken at an edge
// where start is high and busy is low. Each beat yields one result on
// verdict, matched_level and tokens_left, marked by done for one cycle.
// With the back end idle, installs and non-IPv4 packets are answered
// straight from IDLE. A police request scans the slots one per cycle in
// priority order (five-tuple, pair, source) with registered key reads; a
// hit then passes through READ, MUL and FIN before it answers, and a miss
// answers once the last slot has been compared. One item is worked at a
// time, so the scan sets the rate. A two-entry queue
// holds accepted beats while the back end works; busy is high while it is full.
// Reset (rst, synchronous) empties the queue and invalidates every rule.
// The receiver cannot stall; results are shown once.
`include "three_level_token_bucket_policer_macros.svh"
module three_level_token_bucket_policer #(
  parameter int FLOW_SLOTS = 64,
  parameter int PAIR_SLOTS = 64,
  parameter int HOST_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [1:0]  rule_level,
  input  logic [5:0]  entry_index,
  input  logic [15:0] refill_rate,
  input  logic [1:0]  header_class,
  input  logic [7:0]  ip_proto,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [15:0] src_port_num,
  input  logic [15:0] dst_port_num,
  input  logic [39:0] byte_count,
  input  logic [63:0] now_ns,
  output logic        done,
  output logic        verdict,
  output logic [1:0]  matched_level,
  output logic [39:0] tokens_left
);
  tlp_pkg::req_t in_req, head;
  logic full, have, pop, push;

  assign push = start && !busy;
  assign busy = full;
  assign in_req = '{install: req_type, level: rule_level, idx: entry_index,
                    rate: refill_rate, hclass: header_class, proto: ip_proto,
                    src: src_addr, dst: dst_addr, ports: {src_port_num, dst_port_num},
                    bytes: byte_count, now: now_ns};

  tlp_front u_front (
    .clk(clk), .rst(rst), .push(push), .push_req(in_req), .pop(pop),
    .full(full), .not_empty(have), .head(head)
  );

  tlp_back #(.FLOW_SLOTS(FLOW_SLOTS), .PAIR_SLOTS(PAIR_SLOTS), .HOST_SLOTS(HOST_SLOTS)) u_back (
    .clk(clk), .rst(rst), .have(have), .req(head), .pop(pop), .done(done),
    .verdict(verdict), .matched_level(matched_level), .tokens_left(tokens_left)
  );

  `TLP_ASSERT_IMPL(a_pop_done, clk, rst, pop, done, "pop without result")
  `TLP_ASSERT_IMPL(a_pop_have, clk, rst, pop, have, "pop of empty queue")
  `TLP_ASSERT_IMPL(a_none_zero, clk, rst, done && matched_level == tlp_pkg::HIT_NONE,
    tokens_left == 40'd0 && !verdict, "unmatched result not zero")
endmodule

@@ sv/tlp_front.sv @@
// Front end: two-entry queue of accepted beats.
// Depends on tlp_pkg.
module tlp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tlp_pkg::req_t  push_req,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output tlp_pkg::req_t  head
);
  tlp_pkg::req_t q [2];
  logic [1:0] count;
  logic wp, rp;

  assign full = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign head = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= push_req;
    if (rst) begin
      count <= '0;
      wp <= 1'b0;
      rp <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

@@ sv/tlp_back.sv @@
// Back end: rule install, sequential slot scan and bucket update.
// Depends on tlp_pkg.
module tlp_back #(
  parameter int FLOW_SLOTS = 64,
  parameter int PAIR_SLOTS = 64,
  parameter int HOST_SLOTS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          have,
  input  tlp_pkg::req_t req,
  output logic          pop,
  output logic          done,
  output logic          verdict,
  output logic [1:0]    matched_level,
  output logic [39:0]   tokens_left
);
  localparam int TOTAL = FLOW_SLOTS + PAIR_SLOTS + HOST_SLOTS;
  localparam int SW = $clog2(TOTAL + 1);
  localparam int FW = FLOW_SLOTS > 1 ? $clog2(FLOW_SLOTS) : 1;

  typedef enum logic [2:0] {IDLE, SCAN, READ, MUL, FIN} state_t;
  state_t state;

  logic [TOTAL-1:0] valid;
  logic [31:0] k_src [TOTAL];
  logic [31:0] k_dst [TOTAL];
  logic [31:0] k_ports [FLOW_SLOTS];
  logic [7:0]  k_proto [FLOW_SLOTS];
  logic [15:0] b_rate [TOTAL];
  logic [39:0] b_cap [TOTAL];
  logic [39:0] b_tok [TOTAL];
  logic [63:0] b_stamp [TOTAL];

  logic [SW-1:0] ptr, hit;
  logic [1:0] lvl;
  logic [15:0] r_rate;
  logic [39:0] r_cap, r_tok;
  logic [31:0] r_el;
  logic [63:0] prod;
  logic [63:0] fresh;
  logic [63:0] capped;
  logic l4, kmatch;
  logic [SW-1:0] wslot;
  logic wok;
  logic rd_live, rd_valid;
  logic [SW-1:0] rd_slot;
  logic [31:0] rd_src, rd_dst, rd_ports;
  logic [7:0] rd_proto;

  assign l4 = req.hclass == tlp_pkg::CLS_L4 &&
              (req.proto == tlp_pkg::PROTO_TCP || req.proto == tlp_pkg::PROTO_UDP);

  // compare against the keys read on the previous cycle
  always_comb begin
    kmatch = 1'b0;
    if (rd_slot < SW'(FLOW_SLOTS))
      kmatch = l4 && rd_valid && rd_src == req.src && rd_dst == req.dst
               && rd_ports == req.ports && rd_proto == req.proto;
    else if (rd_slot < SW'(FLOW_SLOTS + PAIR_SLOTS))
      kmatch = rd_valid && rd_src == req.src && rd_dst == req.dst;
    else
      kmatch = rd_valid && rd_src == req.src;
  end

  always_comb begin
    wok = 1'b0;
    wslot = '0;
    unique case (req.level)
      tlp_pkg::LVL_FLOW: begin
        wok = {26'd0, req.idx} < FLOW_SLOTS;
        wslot = SW'(req.idx);
      end
      tlp_pkg::LVL_PAIR: begin
        wok = {26'd0, req.idx} < PAIR_SLOTS;
        wslot = SW'(FLOW_SLOTS) + SW'(req.idx);
      end
      tlp_pkg::LVL_HOST: begin
        wok = {26'd0, req.idx} < HOST_SLOTS;
        wslot = SW'(FLOW_SLOTS + PAIR_SLOTS) + SW'(req.idx);
      end
      default: wok = 1'b0;
    endcase
  end

  assign fresh = {24'd0, r_tok} + prod;
  assign capped = fresh > {24'd0, r_cap} ? {24'd0, r_cap} : fresh;

  always_ff @(posedge clk) begin
    pop <= 1'b0;
    done <= 1'b0;
    if (rst) begin
      state <= IDLE;
      valid <= '0;
      rd_live <= 1'b0;
      verdict <= 1'b0;
      matched_level <= tlp_pkg::HIT_NONE;
      tokens_left <= '0;
    end else begin
      unique case (state)
        IDLE: if (have && !pop) begin
          verdict <= 1'b0;
          matched_level <= tlp_pkg::HIT_NONE;
          tokens_left <= '0;
          if (req.install) begin
            if (wok) begin
              valid[wslot] <= 1'b1;
              k_src[wslot] <= req.src;
              k_dst[wslot] <= req.dst;
              if (req.level == tlp_pkg::LVL_FLOW) begin
                k_ports[wslot[FW-1:0]] <= req.ports;
                k_proto[wslot[FW-1:0]] <= req.proto;
              end
              b_rate[wslot] <= req.rate;
              b_cap[wslot] <= req.bytes;
              b_tok[wslot] <= req.bytes;
              b_stamp[wslot] <= req.now;
            end
            pop <= 1'b1;
            done <= 1'b1;
          end else if (req.hclass == tlp_pkg::CLS_IP || req.hclass == tlp_pkg::CLS_L4) begin
            ptr <= '0;
            rd_live <= 1'b0;
            state <= SCAN;
          end else begin
            pop <= 1'b1;
            done <= 1'b1;
          end
        end
        SCAN: begin
          if (rd_live && kmatch) begin
            hit <= rd_slot;
            lvl <= rd_slot < SW'(FLOW_SLOTS) ? tlp_pkg::HIT_FLOW :
                   rd_slot < SW'(FLOW_SLOTS + PAIR_SLOTS) ? tlp_pkg::HIT_PAIR :
                   tlp_pkg::HIT_HOST;
            state <= READ;
          end else if (rd_live && rd_slot == SW'(TOTAL - 1)) begin
            pop <= 1'b1;
            done <= 1'b1;
            state <= IDLE;
          end else begin
            rd_valid <= valid[ptr];
            rd_src <= k_src[ptr];
            rd_dst <= k_dst[ptr];
            rd_ports <= k_ports[ptr[FW-1:0]];
            rd_proto <= k_proto[ptr[FW-1:0]];
            rd_slot <= ptr;
            rd_live <= 1'b1;
            ptr <= ptr + 1'b1;
          end
        end
        READ: begin
          r_rate <= b_rate[hit];
          r_cap <= b_cap[hit];
          r_tok <= b_tok[hit];
          r_el <= (req.now - b_stamp[hit]) > tlp_pkg::MAX_ELAPSED ?
                  32'(tlp_pkg::MAX_ELAPSED) : 32'(req.now - b_stamp[hit]);
          state <= MUL;
        end
        MUL: begin
          prod <= 64'({16'd0, r_el} * {32'd0, r_rate});
          state <= FIN;
        end
        FIN: begin
          if (capped >= {24'd0, req.bytes}) begin
            b_tok[hit] <= capped[39:0] - req.bytes;
            tokens_left <= capped[39:0] - req.bytes;
            verdict <= 1'b0;
          end else begin
            b_tok[hit] <= capped[39:0];
            tokens_left <= capped[39:0];
            verdict <= 1'b1;
          end
          b_stamp[hit] <= req.now;
          matched_level <= lvl;
          pop <= 1'b1;
          done <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule
